### design/bgao_pkg.sv
package bgao_pkg;

	localparam int NowW    = 64;
	localparam int AdcRawW = 12;
	localparam int GainW   = 16;
	localparam int OffsetW = 10;
	localparam int PctW    = 7;
	localparam int IntvW   = 32;
	localparam int MinW    = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDatW = 32;

	// auto-off limit in microseconds: minutes * 60 s * 1e6 us
	localparam int LimitW = 42;
	localparam logic [25:0] UsPerMinute = 26'd60000000;

	localparam logic [PctW-1:0] FullPct = 7'd100;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_ADC_PRESENT  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_GAIN_Q16     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_OFFSET_PCT   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_LOW_THRESH   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CRIT_THRESH  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_REFRESH_US   = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_AUTO_OFF_MIN = 3'd6;

	typedef enum logic [1:0] {
		LVL_NORMAL   = 2'd0,
		LVL_LOW      = 2'd1,
		LVL_CRITICAL = 2'd2
	} level_t;

	typedef struct packed {
		logic [NowW-1:0]    now_us;
		logic [AdcRawW-1:0] adc_raw;
		logic               adc_ok;
		logic               charging;
		logic               restart_timer;
	} in_item_t;

	typedef struct packed {
		logic [PctW-1:0] percent;
		level_t          level;
		logic            shutdown;
		logic            auto_off_expired;
	} out_item_t;

endpackage

### design/battery_gauge_and_auto_off.sv
// Battery gauge with level classification and auto-off timer. Each input
// transfer carries a microsecond timestamp, one ADC sample with its read-ok
// flag, the charger status and a timer-restart flag; each produces exactly
// one result transfer with the percent (0..100), the level (normal, low,
// critical), a shutdown request (critical and not charging) and the auto-off
// expiry flag. The block takes one item per clock unless a stalled output
// backs up into stage 1. Stage 1 registers the item, stage 2 holds the
// scaled sample (16x12 multiply, offset, clamp), and the per-item state
// update (refresh-interval check against the last read time, cached
// percent, timer start) resolves combinationally between stage 2 and the
// output register, so back-to-back items see each other's updates. Both
// channels use valid/stall; a stalled output still lets empty stages fill.
// Configuration registers are written through cfg_valid/cfg_ready (always
// ready) and must only change while the block holds no items.
module battery_gauge_and_auto_off #(
	parameter int ADC_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bgao_pkg::in_item_t            in_data,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output bgao_pkg::out_item_t           out_data,
	// configuration writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgao_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bgao_pkg::CfgDatW-1:0]  cfg_data
);

	// only the low ADC_BITS of the sample field are meaningful
	localparam logic [bgao_pkg::AdcRawW-1:0] RawMask =
		bgao_pkg::AdcRawW'((64'd1 << ADC_BITS) - 64'd1);

	localparam int ProdW   = bgao_pkg::AdcRawW + bgao_pkg::GainW;
	localparam int ScaledW = ProdW - 16;

	// ---------------- configuration registers ----------------
	logic                          adc_present_q;
	logic [bgao_pkg::GainW-1:0]    gain_q;
	logic [bgao_pkg::OffsetW-1:0]  offset_q;
	logic [bgao_pkg::PctW-1:0]     low_thr_q;
	logic [bgao_pkg::PctW-1:0]     crit_thr_q;
	logic [bgao_pkg::IntvW-1:0]    refresh_q;
	logic [bgao_pkg::MinW-1:0]     off_min_q;
	logic [bgao_pkg::LimitW-1:0]   off_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_present_q <= 1'b1;
			gain_q        <= 16'd6214;
			offset_q      <= 10'd250;
			low_thr_q     <= 7'd15;
			crit_thr_q    <= 7'd5;
			refresh_q     <= 32'd5000000;
			off_min_q     <= '0;
			off_limit_q   <= '0;
		end else begin
			// limit follows the minutes register in the next cycle; an item passes
			// stage 1 and stage 2 before it reaches the logic that uses it
			off_limit_q <= bgao_pkg::LimitW'(off_min_q * bgao_pkg::UsPerMinute);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bgao_pkg::REG_ADC_PRESENT:  adc_present_q <= cfg_data[0];
					bgao_pkg::REG_GAIN_Q16:     gain_q        <= cfg_data[15:0];
					bgao_pkg::REG_OFFSET_PCT:   offset_q      <= cfg_data[9:0];
					bgao_pkg::REG_LOW_THRESH:   low_thr_q     <= cfg_data[6:0];
					bgao_pkg::REG_CRIT_THRESH:  crit_thr_q    <= cfg_data[6:0];
					bgao_pkg::REG_REFRESH_US:   refresh_q     <= cfg_data;
					bgao_pkg::REG_AUTO_OFF_MIN: off_min_q     <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- flow control ----------------
	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3   = !valid_s3 || !out_stall;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	// ---------------- stage 1: input register ----------------
	bgao_pkg::in_item_t item_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) item_s1 <= in_data;
	end

	// ---------------- stage 1 -> 2: scale the sample ----------------
	logic [ProdW-1:0]              prod;
	logic [ScaledW-1:0]            scaled;
	logic [ScaledW-1:0]            net;
	logic [bgao_pkg::PctW-1:0]     scaled_pct;

	always_comb begin
		prod = ProdW'(item_s1.adc_raw & RawMask) * ProdW'(gain_q);
		scaled = prod[ProdW-1:16];
		net = scaled - ScaledW'(offset_q);
		if (scaled <= ScaledW'(offset_q))
			scaled_pct = '0;
		else if (net > ScaledW'(bgao_pkg::FullPct))
			scaled_pct = bgao_pkg::FullPct;
		else
			scaled_pct = net[bgao_pkg::PctW-1:0];
	end

	bgao_pkg::in_item_t         item_s2;
	logic [bgao_pkg::PctW-1:0]  scaled_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			item_s2   <= item_s1;
			scaled_s2 <= scaled_pct;
		end
	end

	// ---------------- stage 2 -> 3: state update and result ----------------
	logic [bgao_pkg::PctW-1:0]  cached_pct_q;
	logic [bgao_pkg::NowW-1:0]  last_read_q;
	logic [bgao_pkg::NowW-1:0]  off_start_q;

	logic                       fire_s2;
	logic [bgao_pkg::NowW-1:0]  since_read;
	logic                       read_due;
	logic                       take_read;
	logic [bgao_pkg::PctW-1:0]  pct;
	bgao_pkg::level_t           lvl;
	logic [bgao_pkg::NowW-1:0]  since_start;
	logic                       expired;

	assign fire_s2 = valid_s2 && rdy_s3;

	always_comb begin
		// time differences wrap modulo 2^64
		since_read = item_s2.now_us - last_read_q;
		read_due   = since_read >= bgao_pkg::NowW'(refresh_q);
		take_read  = adc_present_q && read_due;

		if (!adc_present_q)
			pct = bgao_pkg::FullPct;
		else if (!read_due)
			pct = cached_pct_q;
		else if (!item_s2.adc_ok)
			pct = bgao_pkg::FullPct;     // failed read, cache untouched
		else
			pct = scaled_s2;

		if (pct > low_thr_q)
			lvl = bgao_pkg::LVL_NORMAL;
		else if (pct > crit_thr_q)
			lvl = bgao_pkg::LVL_LOW;
		else
			lvl = bgao_pkg::LVL_CRITICAL;

		// restart captures now before expiry is checked
		since_start = item_s2.restart_timer ? '0 : item_s2.now_us - off_start_q;
		// floor(d / 1e6) >= min * 60  <=>  d >= min * 60e6
		expired = (off_min_q != '0) &&
			(since_start >= bgao_pkg::NowW'(off_limit_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_pct_q <= bgao_pkg::FullPct;
			last_read_q  <= '0;
			off_start_q  <= '0;
		end else if (fire_s2) begin
			if (take_read) begin
				last_read_q <= item_s2.now_us;
				if (item_s2.adc_ok) cached_pct_q <= scaled_s2;
			end
			if (item_s2.restart_timer) off_start_q <= item_s2.now_us;
		end
	end

	bgao_pkg::out_item_t result_s3;

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			result_s3.percent          <= pct;
			result_s3.level            <= lvl;
			result_s3.shutdown         <= (lvl == bgao_pkg::LVL_CRITICAL) &&
				!item_s2.charging;
			result_s3.auto_off_expired <= expired;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = result_s3;

endmodule

### tb/gauge_tb_pkg.sv
package gauge_tb_pkg;

	import bgao_pkg::*;

	class gauge_scoreboard;

		// register copies
		logic                adc_present;
		logic [GainW-1:0]    gain_q16;
		logic [OffsetW-1:0]  offset_pct;
		logic [PctW-1:0]     low_thresh;
		logic [PctW-1:0]     crit_thresh;
		logic [IntvW-1:0]    refresh_us;
		logic [MinW-1:0]     auto_off_min;

		// gauge state
		logic [PctW-1:0]     cached_pct;
		logic [NowW-1:0]     last_read_us;
		logic [NowW-1:0]     timer_start_us;

		out_item_t           expected_q[$];
		int                  failures;

		function new();
			adc_present    = 1'b1;
			gain_q16       = 16'd6214;
			offset_pct     = 10'd250;
			low_thresh     = 7'd15;
			crit_thresh    = 7'd5;
			refresh_us     = 32'd5000000;
			auto_off_min   = '0;
			cached_pct     = FullPct;
			last_read_us   = '0;
			timer_start_us = '0;
			failures       = 0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
			case (idx)
				REG_ADC_PRESENT:  adc_present  = val[0];
				REG_GAIN_Q16:     gain_q16     = val[GainW-1:0];
				REG_OFFSET_PCT:   offset_pct   = val[OffsetW-1:0];
				REG_LOW_THRESH:   low_thresh   = val[PctW-1:0];
				REG_CRIT_THRESH:  crit_thresh  = val[PctW-1:0];
				REG_REFRESH_US:   refresh_us   = val[IntvW-1:0];
				REG_AUTO_OFF_MIN: auto_off_min = val[MinW-1:0];
				default: ;
			endcase
		endfunction

		// floor(raw * gain / 2^16) - offset, clamped to 0..100
		function logic [PctW-1:0] scaled_percent(logic [AdcRawW-1:0] raw);
			logic [27:0] product;
			logic [11:0] whole;
			logic [11:0] diff;
			product = 28'(raw) * 28'(gain_q16);
			whole   = product[27:16];
			if (whole <= 12'(offset_pct))
				return '0;
			diff = whole - 12'(offset_pct);
			return (diff > 12'(FullPct)) ? FullPct : diff[PctW-1:0];
		endfunction

		function void note_input(in_item_t it);
			out_item_t       res;
			logic [PctW-1:0] pct;
			level_t          lvl;
			logic [NowW-1:0] secs;
			if (!adc_present) begin
				pct = FullPct;
			end else if (it.now_us - last_read_us < 64'(refresh_us)) begin
				pct = cached_pct;
			end else begin
				last_read_us = it.now_us;
				if (!it.adc_ok) begin
					pct = FullPct;
				end else begin
					pct        = scaled_percent(it.adc_raw);
					cached_pct = pct;
				end
			end
			if (pct > low_thresh)
				lvl = LVL_NORMAL;
			else if (pct > crit_thresh)
				lvl = LVL_LOW;
			else
				lvl = LVL_CRITICAL;
			if (it.restart_timer)
				timer_start_us = it.now_us;
			res.auto_off_expired = 1'b0;
			if (auto_off_min != '0) begin
				secs = (it.now_us - timer_start_us) / 64'd1000000;
				res.auto_off_expired = (secs >= 64'(auto_off_min) * 64'd60);
			end
			res.percent  = pct;
			res.level    = lvl;
			res.shutdown = (lvl == LVL_CRITICAL) && !it.charging;
			expected_q.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing pending: percent %0d level %0d", got.percent,
					got.level);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.percent !== want.percent) begin
				$error("percent: expected %0d, actual %0d", want.percent, got.percent);
				failures++;
			end
			if (got.level !== want.level) begin
				$error("level: expected %0d, actual %0d", want.level, got.level);
				failures++;
			end
			if (got.shutdown !== want.shutdown) begin
				$error("shutdown: expected %0b, actual %0b", want.shutdown, got.shutdown);
				failures++;
			end
			if (got.auto_off_expired !== want.auto_off_expired) begin
				$error("auto_off_expired: expected %0b, actual %0b", want.auto_off_expired,
					got.auto_off_expired);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

	endclass

endpackage

### tb/battery_gauge_and_auto_off_test.sv
module battery_gauge_and_auto_off_test;

	timeunit 1ns;
	timeprecision 1ps;

	import bgao_pkg::*;
	import gauge_tb_pkg::*;

	// index 7 has no register behind it; writes there must be dropped
	localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

	// cycles without any transfer before the run is declared hung
	localparam int HangLimit = 2000;

	typedef struct {
		logic                present;
		logic [GainW-1:0]    gain;
		logic [OffsetW-1:0]  offset;
		logic [PctW-1:0]     low;
		logic [PctW-1:0]     crit;
		logic [IntvW-1:0]    refresh;
		logic [MinW-1:0]     minutes;
	} gauge_setting_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIdxW-1:0]   cfg_index;
	logic [CfgDatW-1:0]   cfg_data;

	gauge_scoreboard sb = new();

	// idle percentages for the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;

	// running timestamp and a copy of the settings that shape the random items
	logic [NowW-1:0]    clock_us = '0;
	logic [IntvW-1:0]   refresh_now = 32'd5000000;
	logic [GainW-1:0]   gain_now = 16'd6214;
	logic [OffsetW-1:0] offset_now = 10'd250;

	gauge_setting_t fixed_set[4];

	battery_gauge_and_auto_off i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: check every accepted transfer, then pick the stall for the
	// next cycle. All reads happen right after the edge, before any NBA lands.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(out_data);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Hang detector: any transfer on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= HangLimit) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
	end

	// One register write; cfg_valid stays high so writes can go back to back.
	// The caller lowers it once the batch is done.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// Write every register; random junk rides in the unused upper bits so
	// masking gets exercised too.
	task automatic apply_setting(input gauge_setting_t s);
		write_reg(REG_ADC_PRESENT,  {31'($urandom), s.present});
		write_reg(REG_GAIN_Q16,     {16'($urandom), s.gain});
		write_reg(REG_OFFSET_PCT,   {22'($urandom), s.offset});
		write_reg(REG_LOW_THRESH,   {25'($urandom), s.low});
		write_reg(REG_CRIT_THRESH,  {25'($urandom), s.crit});
		write_reg(REG_REFRESH_US,   s.refresh);
		write_reg(REG_AUTO_OFF_MIN, {16'($urandom), s.minutes});
		write_reg(RegUnused,        $urandom);
		cfg_valid <= 1'b0;
		refresh_now = s.refresh;
		gain_now    = s.gain;
		offset_now  = s.offset;
	endtask

	// Present one item and hold it until the transfer happens. Idle cycles
	// come first, so valid never reacts to stall.
	task automatic push_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
	endtask

	// Every item yields a result, so an empty queue means the pipe is empty;
	// a few extra cycles catch any stray result.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic in_item_t make_item(input logic [NowW-1:0] t, input logic [AdcRawW-1:0] raw,
		input logic ok, input logic chg, input logic rst);
		in_item_t it;
		it.now_us        = t;
		it.adc_raw       = raw;
		it.adc_ok        = ok;
		it.charging      = chg;
		it.restart_timer = rst;
		return it;
	endfunction

	// Mostly forward time: steps inside the refresh window (cached), just past
	// it (fresh read), long jumps for the timer, some backward steps and some
	// fully random stamps. Raw values lean toward the band where the scaled
	// percent lands near the thresholds.
	function automatic in_item_t next_random_item();
		in_item_t        it;
		int              roll;
		logic [31:0]     span;
		logic [NowW-1:0] target;
		roll = $urandom_range(99);
		span = (refresh_now > 32'd20000000) ? 32'd20000000 : refresh_now;
		if (roll < 40)
			clock_us += 64'($urandom_range(span));
		else if (roll < 80)
			clock_us += 64'(refresh_now) + 64'($urandom_range(2000000));
		else if (roll < 90)
			clock_us += 64'($urandom_range(60000000));
		else if (roll < 95)
			clock_us -= 64'($urandom_range(5000000, 1));
		else
			clock_us = {$urandom, $urandom};
		it.now_us = clock_us;

		roll = $urandom_range(99);
		if (roll < 30 && gain_now != '0) begin
			target = ((64'(offset_now) + 64'($urandom_range(110))) << 16) / 64'(gain_now)
				+ 64'($urandom_range(1));
			it.adc_raw = (target > 64'd4095) ? 12'($urandom) : target[AdcRawW-1:0];
		end else if (roll < 35) begin
			it.adc_raw = '0;
		end else if (roll < 40) begin
			it.adc_raw = '1;
		end else begin
			it.adc_raw = 12'($urandom);
		end
		it.adc_ok        = ($urandom_range(99) < 85);
		it.charging      = 1'($urandom_range(1));
		it.restart_timer = ($urandom_range(9) == 0);
		return it;
	endfunction

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;

		// reset-value setting with a short timer, then the extremes
		fixed_set[0] = '{1'b1, 16'd6214, 10'd250, 7'd15, 7'd5, 32'd5000000, 16'd2};
		fixed_set[1] = '{1'b1, 16'hFFFF, 10'd0, 7'd100, 7'd100, 32'd0, 16'hFFFF};
		fixed_set[2] = '{1'b1, 16'd0, 10'd1023, 7'd0, 7'd0, 32'hFFFF_FFFF, 16'd1};
		fixed_set[3] = '{1'b0, 16'd6214, 10'd250, 7'd50, 7'd20, 32'd1000000, 16'd3};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset settings (refresh 5 s, gain 6214, offset 250) ---
		// first stamp equals the reset read time: cached 100
		push_item(make_item(64'd0, 12'hFFF, 1'b1, 1'b0, 1'b0));
		push_item(make_item(64'd5000000, 12'hFFF, 1'b1, 1'b0, 1'b0));   // clamps to 100
		push_item(make_item(64'd10000000, 12'd0, 1'b1, 1'b0, 1'b0));    // 0: critical, shutdown
		push_item(make_item(64'd15000000, 12'd0, 1'b1, 1'b1, 1'b0));    // charging blocks shutdown
		push_item(make_item(64'd20000000, 12'd2690, 1'b1, 1'b0, 1'b0)); // 5: still critical
		push_item(make_item(64'd25000000, 12'd2795, 1'b1, 1'b0, 1'b0)); // 15: low
		push_item(make_item(64'd30000000, 12'd2806, 1'b1, 1'b0, 1'b0)); // 16: normal
		push_item(make_item(64'd31000000, 12'd0, 1'b1, 1'b0, 1'b0));    // inside window: cached
		push_item(make_item(64'd35000000, 12'd0, 1'b0, 1'b0, 1'b0));    // failed read: 100
		push_item(make_item(64'd36000000, 12'd0, 1'b1, 1'b0, 1'b0));    // cache survived
		// time runs backwards: looks like a huge gap, so a fresh read
		push_item(make_item(64'd1000, 12'd2743, 1'b1, 1'b0, 1'b0));
		push_item(make_item('1, 12'hFFF, 1'b1, 1'b1, 1'b1));
		// wrap from all ones to zero is a one-microsecond step
		push_item(make_item(64'd0, 12'd0, 1'b1, 1'b0, 1'b0));
		drain();

		// --- directed timer: one minute, read on every item ---
		write_reg(REG_AUTO_OFF_MIN, 32'd1);
		write_reg(REG_REFRESH_US, 32'd0);
		write_reg(REG_ADC_PRESENT, 32'hFFFF_FFFF);
		write_reg(RegUnused, 32'hFFFF_FFFF);
		cfg_valid <= 1'b0;
		push_item(make_item(64'd100000000, 12'd3000, 1'b1, 1'b0, 1'b1));
		push_item(make_item(64'd159999999, 12'd2700, 1'b1, 1'b1, 1'b0)); // 59.999999 s
		push_item(make_item(64'd160000000, 12'd2750, 1'b1, 1'b0, 1'b0)); // exactly 60 s
		push_item(make_item(64'd150000000, 12'd3100, 1'b1, 1'b0, 1'b0)); // behind the start
		drain();

		// --- directed extremes: full gain, zero offset, longest interval and timer ---
		write_reg(REG_GAIN_Q16, 32'h0000_FFFF);
		write_reg(REG_OFFSET_PCT, 32'd0);
		write_reg(REG_LOW_THRESH, 32'd100);
		write_reg(REG_CRIT_THRESH, 32'd100);
		write_reg(REG_REFRESH_US, 32'hFFFF_FFFF);
		write_reg(REG_AUTO_OFF_MIN, 32'h0000_FFFF);
		cfg_valid <= 1'b0;
		push_item(make_item(64'd200000000, 12'hFFF, 1'b1, 1'b0, 1'b1));
		push_item(make_item(64'd3932299999999, 12'hFFF, 1'b1, 1'b0, 1'b0)); // one us short
		push_item(make_item(64'd3932300000000, 12'hFFF, 1'b1, 1'b1, 1'b0)); // expires
		drain();
		clock_us = 64'd4000000000000;

		// --- random phases: fixed corner settings first, then random ones ---
		for (int p = 0; p < 8; p++) begin
			gauge_setting_t s;
			if (p < 4) begin
				s = fixed_set[p];
			end else begin
				s.present = ($urandom_range(9) != 0);
				s.gain    = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(12000, 3000));
				s.offset  = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(400));
				s.low     = 7'($urandom_range(100));
				s.crit    = 7'($urandom_range(100));
				s.refresh = ($urandom_range(3) == 0) ? $urandom_range(100)
					: $urandom_range(8000000, 1000000);
				s.minutes = 16'($urandom_range(4));
			end
			drain();
			apply_setting(s);
			// rotate the idle pattern so each setting sees a different one
			case ((p + p / 4) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			for (int n = 0; n < 60; n++)
				push_item(next_random_item());
		end

		drain();
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
